>>> design/arla_pkg.sv
`default_nettype none

package arla_pkg;

    localparam int LINE_BUF_DEF = 6;

    localparam int DIGIT_W     = 17;
    localparam int SUM_W       = 31;
    localparam int CNT_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_RXERR = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;

    localparam logic [7:0] CHAR_START = 8'h52;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        K_DIGIT,
        K_CR,
        K_CLEAR,
        K_POLL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
    } t_op;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

>>> design/arla_front.sv
`default_nettype none

module arla_front import arla_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_byte,
    output logic            o_q_valid,
    output t_op             o_q_op,
    input  wire logic       i_q_pop
);

    logic              w_keep;
    t_op               w_op;
    logic              w_push;
    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic [QPTR_W:0]   n_fill;

    // classify: drop ignored bytes and unused commands here
    always_comb begin
        w_keep     = 1'b0;
        w_op.kind  = K_CLEAR;
        w_op.digit = i_byte[3:0];
        unique case (i_cmd)
            CMD_BYTE: begin
                if (i_byte == CHAR_START) begin
                    w_keep    = 1'b1;
                    w_op.kind = K_CLEAR;
                end else if (i_byte == CHAR_CR) begin
                    w_keep    = 1'b1;
                    w_op.kind = K_CR;
                end else if (i_byte >= CHAR_ZERO && i_byte <= CHAR_NINE) begin
                    w_keep    = 1'b1;
                    w_op.kind = K_DIGIT;
                end
            end
            CMD_RXERR: begin
                w_keep    = 1'b1;
                w_op.kind = K_CLEAR;
            end
            CMD_POLL: begin
                w_keep    = 1'b1;
                w_op.kind = K_POLL;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready && w_keep;
    assign o_q_valid  = (r_fill != '0);
    assign o_q_op     = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (w_push && !i_q_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/arla_div.sv
`default_nettype none

module arla_div import arla_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0] i_den,
    output t_div_res              o_res
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_quot;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[SUM_W-2:0], 1'b0};
                r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_quot <= {r_quot[CNT_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/arla_back.sv
`default_nettype none

module arla_back import arla_pkg::*; #(
    parameter int LINE_BUF = LINE_BUF_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_op         i_q_op,
    output logic             o_q_pop,
    output logic             o_m_valid,
    input  wire logic        i_m_ready,
    output logic             o_m_flag,
    output logic [CNT_W-1:0] o_m_data
);

    localparam int DCNT_W = $clog2(LINE_BUF + 1);
    localparam int DMUL_W = DIGIT_W + 4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    t_state             r_state,  n_state;
    logic [DIGIT_W-1:0] r_digit_value, n_digit_value;
    logic [DCNT_W-1:0]  r_digit_count, n_digit_count;
    logic [SUM_W-1:0]   r_line_sum,    n_line_sum;
    logic [CNT_W-1:0]   r_line_count,  n_line_count;
    logic               r_m_valid,     n_m_valid;
    logic               r_m_flag,      n_m_flag;
    logic [CNT_W-1:0]   r_m_data,      n_m_data;

    logic               w_out_free;
    logic               w_pop;
    logic               w_div_start;
    logic [DMUL_W-1:0]  w_dv_ext;
    logic [DMUL_W-1:0]  w_dv_mul;
    logic [DIGIT_W-1:0] w_dv_sat;
    logic [DCNT_W-1:0]  w_dc_inc;
    logic [SUM_W:0]     w_sum_add;
    t_div_res           w_div;

    assign w_out_free  = !r_m_valid || i_m_ready;
    assign w_pop       = (r_state == ST_IDLE) && i_q_valid
                         && ((i_q_op.kind != K_POLL) || w_out_free);
    assign w_div_start = w_pop && (i_q_op.kind == K_POLL) && (r_line_count != '0);
    assign o_q_pop     = w_pop;

    assign w_dv_ext  = {4'b0, r_digit_value};
    assign w_dv_mul  = (w_dv_ext << 3) + (w_dv_ext << 1) + {{(DMUL_W-4){1'b0}}, i_q_op.digit};
    assign w_dv_sat  = (w_dv_mul > {4'b0, DIGIT_MAX}) ? DIGIT_MAX : w_dv_mul[DIGIT_W-1:0];
    assign w_dc_inc  = r_digit_count + 1'b1;
    assign w_sum_add = {1'b0, r_line_sum}
                       + {{(SUM_W+1-DIGIT_W){1'b0}}, r_digit_value};

    arla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_line_sum),
        .i_den   (r_line_count),
        .o_res   (w_div)
    );

    always_comb begin
        n_state       = r_state;
        n_digit_value = r_digit_value;
        n_digit_count = r_digit_count;
        n_line_sum    = r_line_sum;
        n_line_count  = r_line_count;
        n_m_valid     = r_m_valid && !i_m_ready;
        n_m_flag      = r_m_flag;
        n_m_data      = r_m_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    unique case (i_q_op.kind)
                        K_DIGIT: begin
                            if (w_dc_inc == DCNT_W'(LINE_BUF)) begin
                                n_digit_value = '0;
                                n_digit_count = '0;
                            end else begin
                                n_digit_value = w_dv_sat;
                                n_digit_count = w_dc_inc;
                            end
                        end
                        K_CR: begin
                            n_line_sum    = w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];
                            n_line_count  = (r_line_count == CNT_MAX) ? CNT_MAX
                                            : r_line_count + 1'b1;
                            n_digit_value = '0;
                            n_digit_count = '0;
                        end
                        K_CLEAR: begin
                            n_digit_value = '0;
                            n_digit_count = '0;
                        end
                        K_POLL: begin
                            n_line_sum   = '0;
                            n_line_count = '0;
                            if (r_line_count == '0) begin
                                n_m_valid = 1'b1;
                                n_m_flag  = 1'b0;
                                n_m_data  = '0;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        default: begin
                            n_digit_value = r_digit_value;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_m_valid = 1'b1;
                    n_m_flag  = 1'b1;
                    n_m_data  = w_div.quot;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_digit_value <= '0;
            r_digit_count <= '0;
            r_line_sum    <= '0;
            r_line_count  <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_digit_value <= n_digit_value;
            r_digit_count <= n_digit_count;
            r_line_sum    <= n_line_sum;
            r_line_count  <= n_line_count;
            r_m_valid     <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_flag <= n_m_flag;
        r_m_data <= n_m_data;
    end

    assign o_m_valid = r_m_valid;
    assign o_m_flag  = r_m_flag;
    assign o_m_data  = r_m_data;

`ifndef SYNTHESIS
    a_div_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_m_valid)
        else $error("result register busy during division");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside division state");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count < DCNT_W'(LINE_BUF))
        else $error("digit count reached line buffer size");

    a_empty_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (i_q_op.kind == K_POLL) && (r_line_count == '0))
        |=> (r_m_valid && !r_m_flag && (r_m_data == '0)))
        else $error("poll with no lines gave wrong result");
`endif

endmodule

`default_nettype wire

>>> design/ascii_range_line_averager_top.sv
// channel   | dir | tdata                   | tuser              | tlast
// ----------+-----+-------------------------+--------------------+------
// s_axis    | in  | [7:0] byte_value        | [1:0] command      | -
// m_axis    | out | [15:0] avg_range        | [0] reading_valid  | -
//
// Kept bytes and receive errors are taken by the back part; drop the rest at the front.
// Poll with completed lines: handled in the back part by the 31-step restoring divider.
// Four-entry queue sits between classifier and back part; s_axis_tready drops when full.
// Synchronous active-low reset clears all line state and the queue.
// A held result on m_axis blocks the queue only while a poll is at its head; other transfers keep flowing.
`default_nettype none

module ascii_range_line_averager_top import arla_pkg::*; #(
    parameter int LINE_BUF = LINE_BUF_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] avg_range
    output logic             m_axis_tuser    // [0] reading_valid
);

    logic w_q_valid;
    t_op  w_q_op;
    logic w_q_pop;

    arla_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .o_q_valid  (w_q_valid),
        .o_q_op     (w_q_op),
        .i_q_pop    (w_q_pop)
    );

    arla_back #(
        .LINE_BUF (LINE_BUF)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_op    (w_q_op),
        .o_q_pop   (w_q_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_flag  (m_axis_tuser),
        .o_m_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
